>>> design/mlpt_pkg.sv
// Shared constants, types and helper functions for the page table walker.
`timescale 1ns / 1ps
package mlpt_pkg;

    // Page geometry and store size.
    localparam int OFFSET_BITS = 12;
    localparam int LEVEL_COUNT = 4;
    localparam int FRAME_COUNT = 64;

    localparam int IDX_BITS  = OFFSET_BITS - 3;
    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int NEXT_W    = $clog2(FRAME_COUNT + 1);
    localparam int ADDR_W    = FRAME_W + IDX_BITS;
    localparam int LVL_W     = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int ENTRY_W   = FRAME_W + 1;

    // Operation codes.
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_ALLOCATE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FAULT  = 2'd1,
        ST_NOROOT = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Request and response payloads.
    typedef struct packed {
        logic        opcode;
        logic [63:0] virtual_address;
    } req_t;

    typedef struct packed {
        logic [63:0] physical_address;
        status_t     status;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clear_step;
        logic    load_item;
        logic    set_root;
        logic    frame_from_root;
        logic    mem_read;
        logic    take_entry;
        logic    link_new;
        logic    level_inc;
        logic    out_load;
        status_t out_code;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_alloc;
        logic root_none;
        logic frames_left;
        logic entry_valid;
        logic last_level;
        logic out_free;
    } stat_t;

    // Table index for one level; the first level takes the top index.
    function automatic logic [IDX_BITS-1:0] level_index(
        input logic [63:0]      va,
        input logic [LVL_W-1:0] lvl
    );
        int shift;
        shift = OFFSET_BITS + IDX_BITS * (LEVEL_COUNT - 1 - int'(lvl));
        if (shift >= 64)
        begin
            return '0;
        end
        return IDX_BITS'(va >> shift);
    endfunction

endpackage

>>> design/multilevel_page_table_walker.sv
// Top level of the multilevel page table walker.
`timescale 1ns / 1ps
// Translates or maps one virtual address per transfer through a built-in
// multilevel page table. After reset the block sweeps its table store to zero,
// one entry a cycle, over all 2^(frame bits + index bits) entries (32768 at the
// default geometry) and takes no request meanwhile. A translate or an allocate
// then passes a root step, then for each level walked a registered table store
// read followed by a check and, on allocate, a link write, then a done step that
// loads its response into the output register once that register is free. No
// new request is taken until the response is loaded. A finished response waits
// in an output register, so the next request can be taken while it is still
// stalled.
module multilevel_page_table_walker import mlpt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t  cmd;
    stat_t stat;

    mlpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mlpt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

>>> design/mlpt_dp.sv
// Datapath of the page table walker: table store, allocator, walk registers, result register.
`timescale 1ns / 1ps
module mlpt_dp import mlpt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  cmd_t  cmd,
    output stat_t stat,
    input  logic  rsp_stall,
    output logic  rsp_valid,
    output rsp_t  rsp
);

    // Table store: one valid bit and a frame number per entry.
    logic [ENTRY_W-1:0] mem [2**ADDR_W];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               op_reg;
    logic [63:0]        va_reg;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [FRAME_W-1:0] root_reg, root_next;
    logic [NEXT_W-1:0]  free_reg, free_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg;
    logic [ADDR_W-1:0]  addr;
    logic [FRAME_W-1:0] new_frame;

    assign addr      = {frame_reg, level_index(va_reg, level_reg)};
    assign new_frame = FRAME_W'(free_reg);

    // Status toward the controller.
    assign stat.clear_last  = &clr_cnt_reg;
    assign stat.is_alloc    = (op_reg == OP_ALLOCATE);
    assign stat.root_none   = (root_reg == '0);
    assign stat.frames_left = (free_reg < NEXT_W'(FRAME_COUNT));
    assign stat.entry_valid = rdata_reg[FRAME_W];
    assign stat.last_level  = (level_reg == LVL_W'(LEVEL_COUNT - 1));
    assign stat.out_free    = !out_valid_reg || !rsp_stall;

    // Next values of the walk and allocator registers.
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        frame_next     = frame_reg;
        level_next     = level_reg;
        root_next      = root_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg;
        if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.load_item)
        begin
            level_next = '0;
        end
        if (cmd.set_root)
        begin
            root_next  = new_frame;
            frame_next = new_frame;
            free_next  = free_reg + 1'b1;
        end
        if (cmd.frame_from_root)
        begin
            frame_next = root_reg;
        end
        if (cmd.take_entry)
        begin
            frame_next = rdata_reg[FRAME_W-1:0];
        end
        if (cmd.link_new)
        begin
            frame_next = new_frame;
            free_next  = free_reg + 1'b1;
        end
        if (cmd.level_inc)
        begin
            level_next = level_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            level_reg     <= '0;
            root_reg      <= '0;
            free_reg      <= NEXT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            level_reg     <= level_next;
            root_reg      <= root_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the item in flight and of the result.
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        if (cmd.load_item)
        begin
            op_reg <= req.opcode;
            va_reg <= req.virtual_address;
        end
        if (cmd.out_load)
        begin
            out_reg.status <= cmd.out_code;
            if (cmd.out_code != ST_OK)
            begin
                out_reg.physical_address <= '1;
            end
            else if (op_reg == OP_ALLOCATE)
            begin
                out_reg.physical_address <= 64'(frame_reg) << OFFSET_BITS;
            end
            else
            begin
                out_reg.physical_address <= (64'(frame_reg) << OFFSET_BITS)
                    | (va_reg & ((64'd1 << OFFSET_BITS) - 64'd1));
            end
        end
    end

    // Table store: one write port for clearing and linking, one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.link_new)
        begin
            mem[addr] <= {1'b1, new_frame};
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

>>> design/mlpt_ctrl.sv
// Controller of the page table walker: clearing pass, walk sequencing and result hand-off.
`timescale 1ns / 1ps
module mlpt_ctrl import mlpt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ROOT  = 6'b000100,
        S_READ  = 6'b001000,
        S_EVAL  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    assign req_stall = (state_reg != S_IDLE);

    // Sequencing of one item.
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.out_code = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_ROOT;
                end
            end
            S_ROOT:
            begin
                code_next = ST_OK;
                if (!stat.root_none)
                begin
                    cmd.frame_from_root = 1'b1;
                    state_next          = S_READ;
                end
                else if (!stat.is_alloc)
                begin
                    code_next  = ST_NOROOT;
                    state_next = S_DONE;
                end
                else if (stat.frames_left)
                begin
                    cmd.set_root = 1'b1;
                    state_next   = S_READ;
                end
                else
                begin
                    code_next  = ST_FULL;
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.entry_valid || (stat.is_alloc && stat.frames_left))
                begin
                    cmd.take_entry = stat.entry_valid;
                    cmd.link_new   = !stat.entry_valid;
                    if (stat.last_level)
                    begin
                        code_next  = ST_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.level_inc = 1'b1;
                        state_next    = S_READ;
                    end
                end
                else if (!stat.is_alloc)
                begin
                    code_next  = ST_FAULT;
                    state_next = S_DONE;
                end
                else
                begin
                    code_next  = ST_FULL;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

>>> tb/multilevel_page_table_walker_tb.sv
// Self-checking testbench for the multilevel page table walker.
`timescale 1ns / 1ps
module multilevel_page_table_walker_tb;
    import mlpt_pkg::*;

    localparam int ENTRIES = 1 << IDX_BITS;
    localparam int STORE_SIZE = FRAME_COUNT * ENTRIES;
    localparam int RANDOM_ITEMS = 1880;
    localparam int VA_USED = OFFSET_BITS + IDX_BITS * LEVEL_COUNT;
    localparam int VA_SPARE = 64 - VA_USED;

    // One queued request with the gap that follows it.
    typedef struct {
        req_t item;
        int   gap;
        bit   drain;
    } pending_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Shadow copy of the walker state.
    logic [63:0] shadow_store [0:STORE_SIZE-1];
    int          shadow_root;
    int          shadow_next_free;

    pending_t    request_queue[$];
    rsp_t        expected_rsp[$];
    logic [63:0] mapped_va[$];
    int          error_count;
    int          gap_left;
    int          stall_left;
    int          rsp_seen;
    bit          req_taken;

    multilevel_page_table_walker uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Index of one level; index bits above bit 63 read as zero.
    function automatic int walk_index(logic [63:0] va, int lvl);
        int shift;
        shift = OFFSET_BITS + IDX_BITS * (LEVEL_COUNT - 1 - lvl);
        if (shift >= 64)
        begin
            return 0;
        end
        return int'((va >> shift) & (ENTRIES - 1));
    endfunction

    // Frame named by an entry, zero when the entry is unusable.
    function automatic int linked_frame(logic [63:0] pte);
        logic [63:0] f;
        if (!pte[0])
        begin
            return 0;
        end
        f = pte >> OFFSET_BITS;
        if (f == 0 || f >= FRAME_COUNT)
        begin
            return 0;
        end
        return int'(f);
    endfunction

    function automatic int take_frame();
        if (shadow_next_free >= FRAME_COUNT)
        begin
            return 0;
        end
        shadow_next_free++;
        return shadow_next_free - 1;
    endfunction

    // Walks or extends the shadow tables and returns the expected response.
    function automatic rsp_t walk_tables(req_t r);
        rsp_t res;
        int   frame;
        int   nxt;
        int   addr;
        res.physical_address = '1;
        res.status = ST_OK;
        if (r.opcode == OP_TRANSLATE)
        begin
            frame = shadow_root;
            if (frame == 0)
            begin
                res.status = ST_NOROOT;
            end
            else
            begin
                for (int lvl = 0; lvl < LEVEL_COUNT; lvl++)
                begin
                    addr = frame * ENTRIES + walk_index(r.virtual_address, lvl);
                    frame = linked_frame(shadow_store[addr]);
                    if (frame == 0)
                    begin
                        res.status = ST_FAULT;
                        break;
                    end
                end
                if (res.status == ST_OK)
                begin
                    res.physical_address = (64'(frame) << OFFSET_BITS)
                        | (r.virtual_address & ((64'd1 << OFFSET_BITS) - 1));
                end
            end
        end
        else
        begin
            if (shadow_root == 0)
            begin
                shadow_root = take_frame();
            end
            frame = shadow_root;
            if (frame == 0)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                for (int lvl = 0; lvl < LEVEL_COUNT; lvl++)
                begin
                    addr = frame * ENTRIES + walk_index(r.virtual_address, lvl);
                    nxt = linked_frame(shadow_store[addr]);
                    if (nxt == 0)
                    begin
                        nxt = take_frame();
                        if (nxt == 0)
                        begin
                            res.status = ST_FULL;
                            break;
                        end
                        shadow_store[addr] = (64'(nxt) << OFFSET_BITS) | 64'd1;
                    end
                    frame = nxt;
                end
                if (res.status == ST_OK)
                begin
                    res.physical_address = 64'(frame) << OFFSET_BITS;
                end
            end
        end
        return res;
    endfunction

    // Addresses built from few index values so that tables get shared.
    function automatic logic [63:0] random_va();
        logic [63:0] va;
        int          idx;
        va = {$urandom, $urandom};
        for (int lvl = 0; lvl < LEVEL_COUNT; lvl++)
        begin
            case ($urandom_range(0, 4))
                0: idx = 0;
                1: idx = 1;
                2: idx = ENTRIES - 1;
                3: idx = ENTRIES / 2;
                default: idx = $urandom_range(0, ENTRIES - 1);
            endcase
            va[OFFSET_BITS + IDX_BITS * (LEVEL_COUNT - 1 - lvl) +: IDX_BITS] = IDX_BITS'(idx);
        end
        return va;
    endfunction

    task automatic queue_request(logic op, logic [63:0] va, bit calm, bit drain);
        pending_t p;
        p.item.opcode = op;
        p.item.virtual_address = va;
        p.gap = calm ? 0 : $urandom_range(0, 5);
        p.drain = drain;
        request_queue.push_back(p);
        if (op == OP_ALLOCATE)
        begin
            mapped_va.push_back(va);
        end
    endtask

    // Request driver: new items go out at the falling edge.
    always @(negedge clk)
    begin
        pending_t p;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (req_valid && !req_taken)
        begin
            req_valid <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
        end
        else if (request_queue.size() > 0
                 && !(request_queue[0].drain && expected_rsp.size() > 0))
        begin
            p = request_queue.pop_front();
            req <= p.item;
            req_valid <= 1'b1;
            gap_left <= p.gap;
        end
        else
        begin
            req_valid <= 1'b0;
        end
    end

    // Response stall driver; quiet stretches alternate with random stalls.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Monitor: checks each response transfer and predicts each request transfer.
    always @(posedge clk)
    begin
        rsp_t want;
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen++;
            stall_left <= ((rsp_seen / 150) % 2 == 1) ? 0 : $urandom_range(0, 5);
            if (expected_rsp.size() == 0)
            begin
                $error("Unexpected response transfer: physical_address %h status %0d",
                       rsp.physical_address, rsp.status);
                error_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.physical_address !== want.physical_address)
                begin
                    $error("physical_address mismatch: expected %h actual %h",
                           want.physical_address, rsp.physical_address);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d actual %0d",
                           want.status, rsp.status);
                    error_count++;
                end
            end
        end
        if (rst_n && req_valid && !req_stall)
        begin
            expected_rsp.push_back(walk_tables(req));
        end
    end

    // Stimulus, reset and final verdict.
    initial
    begin
        logic [63:0] va;
        bit          calm;
        int          pick;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        error_count = 0;
        gap_left = 0;
        stall_left = 0;
        rsp_seen = 0;
        req_taken = 1'b0;
        shadow_root = 0;
        shadow_next_free = 1;
        for (int i = 0; i < STORE_SIZE; i++)
        begin
            shadow_store[i] = '0;
        end

        // Directed: missing root, first mapping, hits, faults, field extremes.
        queue_request(OP_TRANSLATE, 64'd0, 0, 0);
        queue_request(OP_TRANSLATE, '1, 0, 0);
        queue_request(OP_ALLOCATE, 64'd0, 0, 0);
        queue_request(OP_TRANSLATE, 64'h0000_0000_0000_0fff, 0, 0);
        queue_request(OP_TRANSLATE, 64'h0000_0000_0000_1000, 0, 0);
        queue_request(OP_TRANSLATE, 64'h0000_8000_0000_0000, 0, 0);
        queue_request(OP_ALLOCATE, '1, 0, 0);
        queue_request(OP_TRANSLATE, '1, 0, 0);
        queue_request(OP_TRANSLATE, 64'h0000_ffff_ffff_f000, 0, 0);
        queue_request(OP_TRANSLATE, 64'hffff_0000_0000_0123, 0, 0);
        queue_request(OP_ALLOCATE, 64'hffff_0000_0000_0000, 0, 1);
        queue_request(OP_ALLOCATE, 64'h0000_0000_0020_0000, 0, 0);
        queue_request(OP_TRANSLATE, 64'h5555_0000_0020_0aaa, 0, 0);
        queue_request(OP_TRANSLATE, 64'h0000_0000_0040_0000, 0, 0);
        queue_request(OP_ALLOCATE, 64'h0000_0000_0020_0555, 0, 0);
        queue_request(OP_TRANSLATE, 64'haaaa_aaaa_aaaa_aaaa, 0, 0);

        // Random: mostly hits on mapped pages, some new mappings and misses.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = ((i / 120) % 3 == 2);
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                queue_request(OP_ALLOCATE, random_va(), calm, i % 400 == 399);
            end
            else if (pick < 70)
            begin
                va = mapped_va[$urandom_range(0, mapped_va.size() - 1)];
                va[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom);
                va[63:VA_USED] = VA_SPARE'($urandom);
                queue_request(OP_TRANSLATE, va, calm, i % 400 == 399);
            end
            else if (pick < 75)
            begin
                queue_request(OP_ALLOCATE, mapped_va[$urandom_range(0, mapped_va.size() - 1)],
                              calm, 0);
            end
            else
            begin
                queue_request(OP_TRANSLATE, random_va(), calm, 0);
            end
        end
        // Make sure the frame supply runs out before the end.
        for (int i = 0; i < 24; i++)
        begin
            queue_request(OP_ALLOCATE, {$urandom, $urandom}, 0, 0);
            queue_request(OP_TRANSLATE, mapped_va[$urandom_range(0, mapped_va.size() - 1)],
                          0, 0);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (request_queue.size() == 0 && !req_valid && expected_rsp.size() == 0);
        repeat (30) @(posedge clk);
        if (error_count == 0 && expected_rsp.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Run limit: clearing sweep plus every item at its slowest, with margin.
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
